[design/acb_pkg.sv]
// Shared types, constants and arithmetic helpers of the autokey letter-pair cipher.
package acb_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_SEED  = 2'd0;
  localparam logic [1:0] REG_MULT_C1   = 2'd1;
  localparam logic [1:0] REG_ADD_C2    = 2'd2;
  localparam logic [1:0] REG_DIRECTION = 2'd3;

  localparam int unsigned CfgWidth = 16;

  localparam logic [15:0] MULT_C1_RESET = 16'd52845;
  localparam logic [15:0] ADD_C2_RESET  = 16'd22719;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  localparam logic [7:0] LETTER_BASE = 8'd65;  // 'A'
  localparam logic [4:0] LETTER_SPAN = 5'd26;
  localparam logic [7:0] TRAIL_P     = 8'h50;  // 'P'
  localparam logic [7:0] TRAIL_C     = 8'h43;  // 'C'

  // One classified beat handed from the front end to the cipher back end
  typedef struct packed {
    logic       first;
    logic       fin;
    logic       dir;
    logic [7:0] data;   // plain byte (encrypt) or cipher byte from the pair (decrypt)
  } op_t;

  typedef struct packed {
    logic [6:0] hi;
    logic [6:0] lo;
  } letters_t;

  // Letter pair to cipher byte: ((hi-65)*26 + (lo-65)) mod 256
  function automatic logic [7:0] pair_to_byte(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [12:0] prod;
    a    = hi - LETTER_BASE;
    b    = lo - LETTER_BASE;
    prod = a * LETTER_SPAN;
    return prod[7:0] + b;
  endfunction

  // Byte to letters 'A'+c/26, 'A'+c%26; c/26 == (c*79)>>11 for all 8-bit c
  function automatic letters_t byte_to_letters(input logic [7:0] c);
    logic [14:0] m;
    logic [3:0]  q;
    logic [8:0]  qx;
    logic [7:0]  r;
    letters_t    res;
    m      = c * 7'd79;
    q      = m[14:11];
    qx     = q * LETTER_SPAN;
    r      = c - qx[7:0];
    res.hi = 7'(LETTER_BASE) + 7'(q);
    res.lo = 7'(LETTER_BASE) + r[6:0];
    return res;
  endfunction

endpackage

[design/acb_front.sv]
// Front end: takes input beats and classifies them into cipher operations.
module acb_front (
  input  logic             in_valid_i,
  input  logic             in_first_i,
  input  logic             in_final_req_i,
  input  logic [7:0]       in_plain_in_i,
  input  logic [7:0]       in_letter_hi_in_i,
  input  logic [7:0]       in_letter_lo_in_i,
  input  logic             dir_i,
  input  logic             full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output acb_pkg::op_t     op_o
);
  import acb_pkg::*;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i;

  always_comb begin
    op_o.first = in_first_i;
    op_o.fin   = in_final_req_i;
    op_o.dir   = dir_i;
    op_o.data  = (dir_i == DIR_DECRYPT) ? pair_to_byte(in_letter_hi_in_i, in_letter_lo_in_i)
                                        : in_plain_in_i;
  end

endmodule

[design/acb_fifo.sv]
// Small register queue of cipher operations between front and back end.
module acb_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  acb_pkg::op_t wdata_i,
  input  logic         pop_i,
  output acb_pkg::op_t rdata_o,
  output logic         full_o,
  output logic         empty_o
);
  import acb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_t           mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_r == CW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[design/acb_back.sv]
// Back end: running-key cipher, trailer sequencing, holdback and output register.
module acb_back (
  input  logic         clk,
  input  logic         rst_n,
  input  acb_pkg::op_t op_i,
  input  logic         empty_i,
  output logic         pop_o,
  input  logic [15:0]  key_seed_i,
  input  logic [15:0]  mult_c1_i,
  input  logic [15:0]  add_c2_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [6:0]   out_letter_hi_out_o,
  output logic [6:0]   out_letter_lo_out_o,
  output logic [7:0]   out_plain_out_o,
  output logic         out_run_last_o
);
  import acb_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_P, PH_C} phase_t;

  phase_t     phase_r, phase_nxt;
  logic [15:0] key_r, key_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  hi_r, hi_nxt;
  logic [6:0]  lo_r, lo_nxt;
  logic [7:0]  plain_r, plain_nxt;
  logic        last_r, last_nxt;

  logic        adv;
  logic        use_first;
  logic [15:0] key_use;
  logic [1:0]  hcnt_use;
  logic [7:0]  src;
  logic        dec;
  logic [7:0]  cbyte;
  logic [7:0]  pbyte;
  logic [15:0] ksum;
  logic [31:0] kprod;
  logic [15:0] key_calc;
  letters_t    lt;

  assign adv   = !out_valid_r || !out_stall_i;
  assign pop_o = adv && (phase_r == PH_IDLE) && !empty_i;

  // first only counts for a beat that is being taken from the queue
  assign use_first = pop_o && op_i.first;
  assign key_use   = use_first ? key_seed_i : key_r;
  assign hcnt_use  = use_first ? 2'd0 : hcnt_r;

  always_comb begin
    unique case (phase_r)
      PH_P:    src = TRAIL_P;
      PH_C:    src = TRAIL_C;
      default: src = op_i.data;
    endcase
  end

  assign dec      = (phase_r == PH_IDLE) && (op_i.dir == DIR_DECRYPT);
  assign pbyte    = src ^ key_use[15:8];
  assign cbyte    = dec ? src : pbyte;
  assign ksum     = key_use + {8'd0, cbyte};
  assign kprod    = ksum * mult_c1_i;
  assign key_calc = kprod[15:0] + add_c2_i;
  assign lt       = byte_to_letters(cbyte);

  always_comb begin
    phase_nxt     = phase_r;
    key_nxt       = key_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    hcnt_nxt      = hcnt_r;
    out_valid_nxt = out_valid_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    plain_nxt     = plain_r;
    last_nxt      = last_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      unique case (phase_r)
        PH_P: begin
          out_valid_nxt = 1'b1;
          hi_nxt        = lt.hi;
          lo_nxt        = lt.lo;
          plain_nxt     = 8'd0;
          last_nxt      = 1'b0;
          key_nxt       = key_calc;
          phase_nxt     = PH_C;
        end
        PH_C: begin
          out_valid_nxt = 1'b1;
          hi_nxt        = lt.hi;
          lo_nxt        = lt.lo;
          plain_nxt     = 8'd0;
          last_nxt      = 1'b1;
          key_nxt       = key_calc;
          phase_nxt     = PH_IDLE;
        end
        PH_IDLE: begin
          if (!empty_i) begin
            key_nxt  = key_calc;
            hcnt_nxt = hcnt_use;
            if (op_i.dir == DIR_ENCRYPT) begin
              out_valid_nxt = 1'b1;
              hi_nxt        = lt.hi;
              lo_nxt        = lt.lo;
              plain_nxt     = 8'd0;
              // a final byte's own result is not the last: the trailer follows
              last_nxt      = !op_i.fin;
              if (op_i.fin) begin
                phase_nxt = PH_P;
              end
            end else begin
              if (hcnt_use == 2'd2) begin
                out_valid_nxt = 1'b1;
                hi_nxt        = 7'd0;
                lo_nxt        = 7'd0;
                plain_nxt     = held0_r;
                last_nxt      = op_i.fin;
                held0_nxt     = held1_r;
                held1_nxt     = pbyte;
              end else begin
                if (hcnt_use[0]) begin
                  held1_nxt = pbyte;
                end else begin
                  held0_nxt = pbyte;
                end
                hcnt_nxt = hcnt_use + 2'd1;
              end
              if (op_i.fin) begin
                hcnt_nxt = 2'd0;
              end
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      key_r       <= '0;
      held0_r     <= '0;
      held1_r     <= '0;
      hcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      key_r       <= key_nxt;
      held0_r     <= held0_nxt;
      held1_r     <= held1_nxt;
      hcnt_r      <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    plain_r <= plain_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid_o         = out_valid_r;
  assign out_letter_hi_out_o = hi_r;
  assign out_letter_lo_out_o = lo_r;
  assign out_plain_out_o     = plain_r;
  assign out_run_last_o      = last_r;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |-> (phase_r == PH_IDLE))
    else $error("queue popped during trailer");

  a_p_then_c: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && phase_r == PH_P) |=> (phase_r == PH_C && out_valid_r && !last_r))
    else $error("trailer P step broken");

  a_c_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && phase_r == PH_C) |=> (phase_r == PH_IDLE && out_valid_r && last_r))
    else $error("trailer C step not marked last");

  a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o && op_i.dir == DIR_DECRYPT && op_i.fin |=> (hcnt_r == 2'd0))
    else $error("holdback not cleared on final");

endmodule

[design/autokey_byte_cipher_letter_pairs_core.sv]
// Top level of the autokey byte cipher with letter-pair coding.
//
// One layer of the C1/C2 key-feedback byte cipher. A 16-bit running key is
// loaded from key_seed on a beat with first set; each byte is XORed with the
// key's high byte and the key becomes (cipher byte + key) * mult_c1 + add_c2
// mod 2^16. Encrypt (direction 0): every plain byte gives one result beat with
// the letters 'A'+c/26 and 'A'+c%26; a final beat also enciphers the trailer
// "PC", so it gives three result beats. run_last is set on the last result
// beat that an input beat causes. Decrypt (direction 1): each letter pair is
// folded to a cipher byte ((hi-65)*26 + (lo-65)) mod 256 and deciphered; two
// deciphered bytes are held back so the trailer drops off unchecked, so
// output runs two beats behind input and short messages give nothing.
// Rate: one input beat per clock while the queue has room; a final encrypt
// beat holds the key loop through its byte and the "PC" trailer (one key
// update per byte, and the key feeds back into the next byte). Structure:
// the front end classifies beats into a 4-deep queue, the back end runs the
// key loop and owns the output register, so input keeps flowing while a
// result waits on out_stall. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
module autokey_byte_cipher_letter_pairs_core #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first,
  input  logic        in_final_req,
  input  logic [7:0]  in_plain_in,
  input  logic [7:0]  in_letter_hi_in,
  input  logic [7:0]  in_letter_lo_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_letter_hi_out,
  output logic [6:0]  out_letter_lo_out,
  output logic [7:0]  out_plain_out,
  output logic        out_run_last
);
  import acb_pkg::*;

  logic [15:0] key_seed_r;
  logic [15:0] mult_c1_r;
  logic [15:0] add_c2_r;
  logic        direction_r;

  op_t  fe_op;
  op_t  q_op;
  logic fe_push;
  logic q_full;
  logic q_empty;
  logic be_pop;

  // Configuration registers; the user must make writes land only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_seed_r  <= '0;
      mult_c1_r   <= MULT_C1_RESET;
      add_c2_r    <= ADD_C2_RESET;
      direction_r <= DIR_ENCRYPT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_SEED:  key_seed_r  <= cfg_data;
        REG_MULT_C1:   mult_c1_r   <= cfg_data;
        REG_ADD_C2:    add_c2_r    <= cfg_data;
        REG_DIRECTION: direction_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front end: beat classification (pair folding happens here)
  acb_front u_front (
    .in_valid_i        (in_valid),
    .in_first_i        (in_first),
    .in_final_req_i    (in_final_req),
    .in_plain_in_i     (in_plain_in),
    .in_letter_hi_in_i (in_letter_hi_in),
    .in_letter_lo_in_i (in_letter_lo_in),
    .dir_i             (direction_r),
    .full_i            (q_full),
    .in_stall_o        (in_stall),
    .push_o            (fe_push),
    .op_o              (fe_op)
  );

  // Decoupling queue
  acb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fe_push),
    .wdata_i (fe_op),
    .pop_i   (be_pop),
    .rdata_o (q_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: key loop, trailer, holdback, output register
  acb_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op_i                (q_op),
    .empty_i             (q_empty),
    .pop_o               (be_pop),
    .key_seed_i          (key_seed_r),
    .mult_c1_i           (mult_c1_r),
    .add_c2_i            (add_c2_r),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_letter_hi_out_o (out_letter_hi_out),
    .out_letter_lo_out_o (out_letter_lo_out),
    .out_plain_out_o     (out_plain_out),
    .out_run_last_o      (out_run_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> in_stall)
    else $error("input taken while queue full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    be_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_cfg_idle_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !be_pop) |=> $stable(q_op))
    else $error("queue head changed without pop");

endmodule
